>>> hw/rtl/tkps_pkg.sv
// Shared types and constants of the top-K pair selector.
// Used by the cell, the top level and the port checker; depends on nothing.
package tkps_pkg;

  // Store depth and derived widths.
  localparam int unsigned MaxKeep = 64;
  localparam int unsigned CntW    = $clog2(MaxKeep + 1);
  localparam int unsigned KeepW   = 7;
  localparam int unsigned LimW    = (CntW > KeepW) ? CntW : KeepW;

  // Field widths.
  localparam int unsigned ScoreW  = 17;
  localparam int unsigned RecW    = 20;
  localparam int unsigned HeldW   = 7;

  // Packed stream word widths, rounded up to whole bytes.
  localparam int unsigned InFieldW  = ScoreW + 2 * RecW;
  localparam int unsigned InDataW   = ((InFieldW + 7) / 8) * 8;
  localparam int unsigned OutFieldW = 1 + HeldW + ScoreW;
  localparam int unsigned OutDataW  = ((OutFieldW + 7) / 8) * 8;

  // Score of 1.0 in Q1.16 and the reset value of the keep count.
  localparam logic [ScoreW-1:0] ScoreOne  = ScoreW'(65536);
  localparam logic [KeepW-1:0]  KeepReset = KeepW'(64);

  // One kept pair.
  typedef struct packed {
    logic [ScoreW-1:0] score;
    logic [RecW-1:0]   left_rec;
    logic [RecW-1:0]   right_rec;
  } entry_t;

  // Control that the top level hands to each cell.
  typedef struct packed {
    logic en;        // an admitted pair is being inserted this cycle
    logic valid;     // this cell holds a kept pair
    logic prev_ins;  // the neighbor above lies at or below the insert point
  } cell_ctl_t;

endpackage

>>> hw/rtl/tkps_cell.sv
// One cell of the sorted chain: holds one kept pair, highest scores at the head.
// Depends on tkps_pkg for the entry and control types.
module tkps_cell (
  input  logic               clk_i,
  input  tkps_pkg::cell_ctl_t ctl_i,
  input  tkps_pkg::entry_t   new_i,
  input  tkps_pkg::entry_t   prev_i,
  output tkps_pkg::entry_t   ent_o,
  output logic               ins_o
);

  tkps_pkg::entry_t ent_q, ent_d;

  // The new pair goes at or above this cell when the cell is empty or weaker.
  assign ins_o = !ctl_i.valid || (new_i.score > ent_q.score);

  // The first cell at the insert point takes the new pair; the ones below shift down.
  always_comb begin
    ent_d = ent_q;
    if (ctl_i.en && ins_o) begin
      if (ctl_i.prev_ins) begin
        ent_d = prev_i;
      end else begin
        ent_d = new_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;

endmodule

>>> hw/rtl/top_k_pair_selector.sv
// Top level of the top-K pair selector: cell chain, count, limit and output stage.
// Depends on tkps_pkg and tkps_cell.
//
// Keeps the keep_count best-scoring pairs in a chain of 64 cells sorted by score,
// highest first, so the lowest kept score always sits in the last valid cell.
// A word can be taken in every cycle while result words are read as they come. The
// chain does its compare-and-shift as it takes a word, the pending stage registers the
// result of that word, and the output register then shows it on the output stream.
// A stalled result word lets one more word in and then holds off the input.
// Scores above 1.0 are clipped to 1.0, a keep_count of zero acts as one, and
// lowering keep_count below the held count keeps every held pair but admits new
// ones only in place of the minimum. Write keep_count only while the block is idle.
module top_k_pair_selector (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tkps_pkg::KeepW-1:0]         cfg_wdata_i,
  input  logic                               s_tvalid_i,
  output logic                               s_tready_o,
  // s_tdata_i: score [16:0], left_record [36:17], right_record [56:37], zeros above.
  input  logic [tkps_pkg::InDataW-1:0]       s_tdata_i,
  output logic                               m_tvalid_o,
  input  logic                               m_tready_i,
  // m_tdata_o: admitted [0], held_count [7:1], min_kept_score [24:8], zeros above.
  output logic [tkps_pkg::OutDataW-1:0]      m_tdata_o
);

  localparam int unsigned N    = tkps_pkg::MaxKeep;
  localparam int unsigned IdxW = $clog2(N);

  logic [tkps_pkg::KeepW-1:0]  keep_q;
  logic [tkps_pkg::CntW-1:0]   count_q, count_d;
  logic                        pend_q, pend_d;
  logic                        pend_adm_q, pend_adm_d;
  logic                        out_valid_q, out_valid_d;
  logic                        out_adm_q;
  logic [tkps_pkg::HeldW-1:0]  out_held_q;
  logic [tkps_pkg::ScoreW-1:0] out_min_q;

  logic                        accept;
  logic                        out_free;
  logic                        pend_move;
  logic                        full;
  logic                        admit;
  logic [tkps_pkg::LimW-1:0]   limit;
  logic [tkps_pkg::ScoreW-1:0] raw_score;
  logic [tkps_pkg::ScoreW-1:0] min_cur;
  tkps_pkg::entry_t            new_ent;
  tkps_pkg::entry_t            ent   [N];
  logic                        ins   [N];
  logic [tkps_pkg::ScoreW-1:0] tail  [N];

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q <= tkps_pkg::KeepReset;
    end else if (cfg_we_i) begin
      keep_q <= cfg_wdata_i;
    end
  end

  // Effective limit: zero acts as one, and it never exceeds the chain length.
  always_comb begin
    limit = tkps_pkg::LimW'(keep_q);
    if (limit == '0) begin
      limit = tkps_pkg::LimW'(1);
    end
    if (limit > tkps_pkg::LimW'(N)) begin
      limit = tkps_pkg::LimW'(N);
    end
  end

  // Unpack the incoming word and clip the score to 1.0.
  assign raw_score = s_tdata_i[tkps_pkg::ScoreW-1:0];
  always_comb begin
    new_ent.score     = (raw_score > tkps_pkg::ScoreOne) ? tkps_pkg::ScoreOne : raw_score;
    new_ent.left_rec  = s_tdata_i[tkps_pkg::ScoreW +: tkps_pkg::RecW];
    new_ent.right_rec = s_tdata_i[tkps_pkg::ScoreW + tkps_pkg::RecW +: tkps_pkg::RecW];
  end

  // Handshake: the pending result moves on whenever the output register is free.
  assign out_free   = !out_valid_q || m_tready_i;
  assign pend_move  = pend_q && out_free;
  assign s_tready_o = !pend_q || out_free;
  assign accept     = s_tvalid_i && s_tready_o;

  // Admission: a free slot, or a score strictly above the current minimum.
  assign full  = tkps_pkg::LimW'(count_q) >= limit;
  assign admit = !full || (new_ent.score > min_cur);

  // The sorted chain.
  for (genvar i = 0; i < N; i++) begin : g_cell
    tkps_pkg::cell_ctl_t ctl;
    tkps_pkg::entry_t    prev_ent;
    logic                up_ins;

    if (i == 0) begin : g_head
      assign up_ins   = 1'b0;
      assign prev_ent = '0;
    end else begin : g_body
      assign up_ins   = ins[i-1];
      assign prev_ent = ent[i-1];
    end

    assign ctl = '{en:       accept && admit,
                   valid:    (tkps_pkg::CntW'(i) < count_q),
                   prev_ins: up_ins};

    tkps_cell u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .new_i  (new_ent),
      .prev_i (prev_ent),
      .ent_o  (ent[i]),
      .ins_o  (ins[i])
    );

    // Only the last valid cell shows its score; the others show zero.
    assign tail[i] = (count_q == tkps_pkg::CntW'(i + 1)) ? ent[i].score : '0;
  end

  // Lowest kept score, zero while the chain is empty.
  always_comb begin
    min_cur = '0;
    for (int i = 0; i < N; i++) begin
      min_cur = min_cur | tail[IdxW'(i)];
    end
  end

  // Held count grows only when a pair fills a free slot.
  always_comb begin
    count_d = count_q;
    if (accept && admit && !full) begin
      count_d = count_q + tkps_pkg::CntW'(1);
    end
  end

  // Pending stage: the result of the last word taken, held until the output register is free.
  always_comb begin
    pend_d     = pend_q;
    pend_adm_d = pend_adm_q;
    if (accept) begin
      pend_d     = 1'b1;
      pend_adm_d = admit;
    end else if (pend_move) begin
      pend_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pend_move) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: the chain already holds the state after the pending word.
  always_ff @(posedge clk_i) begin
    pend_adm_q <= pend_adm_d;
    if (pend_move) begin
      out_adm_q  <= pend_adm_q;
      out_held_q <= tkps_pkg::HeldW'(count_q);
      out_min_q  <= min_cur;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = tkps_pkg::OutDataW'({out_min_q, out_held_q, out_adm_q});

endmodule

>>> hw/rtl/tkps_checker.sv
// Port checker for the top-K pair selector, attached to the top level by bind.
// Depends on tkps_pkg for field widths and the chain length.
module tkps_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_tvalid_o,
  input logic                          m_tready_i,
  input logic [tkps_pkg::OutDataW-1:0] m_tdata_o
);

  logic                        adm;
  logic [tkps_pkg::HeldW-1:0]  held;
  logic [tkps_pkg::ScoreW-1:0] min_s;

  assign adm   = m_tdata_o[0];
  assign held  = m_tdata_o[tkps_pkg::HeldW:1];
  assign min_s = m_tdata_o[tkps_pkg::HeldW + 1 +: tkps_pkg::ScoreW];

  // Every result follows a stored pair, so the held count lies in one to the depth.
  a_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> (held != '0) && (held <= tkps_pkg::HeldW'(tkps_pkg::MaxKeep)))
    else $error("held_count out of range");

  // Kept scores are clipped, so the minimum never exceeds 1.0.
  a_min_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> (min_s <= tkps_pkg::ScoreOne))
    else $error("min_kept_score above 1.0");

  // The held count never drops from one result to the next.
  a_held_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && m_tready_i) ##1 m_tvalid_o |-> held >= $past(held))
    else $error("held_count decreased");

  // A stalled result word holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && !m_tready_i) |=> m_tvalid_o && $stable(m_tdata_o))
    else $error("result word changed while stalled");

  // A rejected pair leaves the minimum where it was.
  a_reject_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && m_tready_i) ##1 (m_tvalid_o && !adm) |-> min_s == $past(min_s))
    else $error("minimum moved on a rejected pair");

endmodule

bind top_k_pair_selector tkps_checker u_tkps_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .m_tvalid_o (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_o  (m_tdata_o)
);

>>> tb/top_k_pair_selector_tb.sv
// Self-checking testbench for the top-K pair selector: offers scored pairs over the
// input stream, predicts each result word and checks every field on the output stream.
// Depends on tkps_pkg and the top_k_pair_selector RTL.
`timescale 1ns / 1ps

module top_k_pair_selector_tb;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned IdlePct    = 38;
  localparam int unsigned PhaseWords = 205;
  localparam int unsigned IdxW       = $clog2(tkps_pkg::MaxKeep);

  // One offered pair, as packed into s_tdata_i from the lowest bit up.
  typedef struct packed {
    logic [tkps_pkg::RecW-1:0]   right_rec;
    logic [tkps_pkg::RecW-1:0]   left_rec;
    logic [tkps_pkg::ScoreW-1:0] score;
  } pair_t;

  // One result word, field by field.
  typedef struct {
    logic                        admitted;
    logic [tkps_pkg::HeldW-1:0]  held;
    logic [tkps_pkg::ScoreW-1:0] min_score;
  } selector_result_t;

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          cfg_we_i    = 1'b0;
  logic [tkps_pkg::KeepW-1:0]    cfg_wdata_i = '0;
  logic                          s_tvalid_i  = 1'b0;
  logic                          s_tready_o;
  logic [tkps_pkg::InDataW-1:0]  s_tdata_i   = '0;
  logic                          m_tvalid_o;
  logic                          m_tready_i  = 1'b0;
  logic [tkps_pkg::OutDataW-1:0] m_tdata_o;

  // Stimulus and scoreboard state.
  pair_t            pair_backlog[$];
  selector_result_t due_results[$];
  pair_t            pair_on_bus;
  bit               pair_taken;
  bit               calm;
  int unsigned      error_count;
  int unsigned      cycle_n;
  int unsigned      results_checked;
  int unsigned      admits_seen;
  int unsigned      clipped_offered;
  int unsigned      settings_used;

  // Shadow of the kept scores, the held count and the keep setting.
  logic [tkps_pkg::ScoreW-1:0] kept_scores[tkps_pkg::MaxKeep];
  int unsigned                 held_n;
  logic [tkps_pkg::KeepW-1:0]  keep_setting;

  top_k_pair_selector u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

  always #5 clk_i = ~clk_i;

  // Slot of the lowest kept score; ties go to the lowest slot.
  function automatic int unsigned lowest_slot();
    int unsigned lo;
    lo = 0;
    for (int unsigned i = 1; i < held_n; i++) begin
      if (kept_scores[IdxW'(i)] < kept_scores[IdxW'(lo)]) lo = i;
    end
    return lo;
  endfunction

  // Offers one pair to the shadow store and returns the result word it should cause.
  function automatic selector_result_t offer_pair(input pair_t p);
    logic [tkps_pkg::ScoreW-1:0] s;
    int unsigned                 limit;
    int unsigned                 lo;
    selector_result_t            r;
    s = (p.score > tkps_pkg::ScoreOne) ? tkps_pkg::ScoreOne : p.score;
    limit = 32'(keep_setting);
    if (limit == 0) limit = 1;
    if (limit > tkps_pkg::MaxKeep) limit = tkps_pkg::MaxKeep;
    r.admitted = 1'b0;
    if (held_n < limit) begin
      kept_scores[IdxW'(held_n)] = s;
      held_n++;
      r.admitted = 1'b1;
    end else if (held_n > 0) begin
      // Full store: only a strictly higher score displaces the minimum.
      lo = lowest_slot();
      if (s > kept_scores[IdxW'(lo)]) begin
        kept_scores[IdxW'(lo)] = s;
        r.admitted = 1'b1;
      end
    end
    r.held = tkps_pkg::HeldW'(held_n);
    r.min_score = (held_n > 0) ? kept_scores[IdxW'(lowest_slot())] : '0;
    return r;
  endfunction

  // Input word driver: a new word goes out only once the previous one was taken.
  always @(negedge clk_i) begin
    if (!s_tvalid_i || pair_taken) begin
      if (pair_backlog.size() > 0 && (calm || $urandom_range(99) >= IdlePct)) begin
        pair_on_bus = pair_backlog.pop_front();
        s_tdata_i <= tkps_pkg::InDataW'(pair_on_bus);
        s_tvalid_i <= 1'b1;
      end else begin
        s_tvalid_i <= 1'b0;
      end
    end
    pair_taken = 1'b0;
  end

  // Output back-pressure.
  always @(negedge clk_i) begin
    m_tready_i <= calm || ($urandom_range(99) >= IdlePct);
  end

  // Checks result words first, then predicts for the input word taken at this edge.
  always @(posedge clk_i) begin
    selector_result_t want;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      if (due_results.size() == 0) begin
        $error("result word %h arrived with nothing due", m_tdata_o);
        error_count++;
      end else begin
        want = due_results.pop_front();
        results_checked++;
        if (m_tdata_o[0] !== want.admitted) begin
          $error("admitted: expected %0d, got %0d", want.admitted, m_tdata_o[0]);
          error_count++;
        end
        if (m_tdata_o[tkps_pkg::HeldW:1] !== want.held) begin
          $error("held_count: expected %0d, got %0d", want.held,
                 m_tdata_o[tkps_pkg::HeldW:1]);
          error_count++;
        end
        if (m_tdata_o[tkps_pkg::HeldW + 1 +: tkps_pkg::ScoreW] !== want.min_score) begin
          $error("min_kept_score: expected %0d, got %0d", want.min_score,
                 m_tdata_o[tkps_pkg::HeldW + 1 +: tkps_pkg::ScoreW]);
          error_count++;
        end
      end
    end
    if (rst_ni && cfg_we_i) keep_setting = cfg_wdata_i;
    if (rst_ni && s_tvalid_i && s_tready_o) begin
      pair_taken = 1'b1;
      want = offer_pair(pair_on_bus);
      if (want.admitted) admits_seen++;
      if (pair_on_bus.score > tkps_pkg::ScoreOne) clipped_offered++;
      due_results.push_back(want);
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_n++;
    if (cycle_n > CycleLimit) begin
      $display("top_k_pair_selector_tb NOT OK");
      $finish;
    end
  end

  // Waits until no word is queued, on the bus or due, then lets the pipe drain.
  task automatic settle();
    do @(negedge clk_i);
    while (pair_backlog.size() > 0 || s_tvalid_i || due_results.size() > 0);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_keep(input logic [tkps_pkg::KeepW-1:0] value);
    settle();
    cfg_wdata_i <= value;
    cfg_we_i <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  task automatic queue_pair(input int unsigned score, input int unsigned left,
                            input int unsigned right);
    pair_t p;
    p.score = tkps_pkg::ScoreW'(score);
    p.left_rec = tkps_pkg::RecW'(left);
    p.right_rec = tkps_pkg::RecW'(right);
    pair_backlog.push_back(p);
  endtask

  // Random pairs: mostly legal scores, a crowd just below 1.0 so that ties with the
  // minimum occur, a low band, and scores above 1.0 that must be clipped.
  task automatic queue_random(input int unsigned n);
    pair_t       p;
    int unsigned pick;
    for (int unsigned k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 45) p.score = tkps_pkg::ScoreW'($urandom_range(65536));
      else if (pick < 65) p.score = tkps_pkg::ScoreW'($urandom_range(65536, 65520));
      else if (pick < 75) p.score = tkps_pkg::ScoreW'($urandom_range(15));
      else if (pick < 88) p.score = tkps_pkg::ScoreW'($urandom_range(131071, 65537));
      else p.score = tkps_pkg::ScoreW'($urandom());
      p.left_rec = tkps_pkg::RecW'($urandom());
      p.right_rec = tkps_pkg::RecW'($urandom());
      pair_backlog.push_back(p);
    end
  endtask

  initial begin
    int unsigned keep_plan[9];
    keep_plan = '{1, 12, 3, 64, 127, 40, 0, 100, 64};
    keep_setting = tkps_pkg::KeepReset;
    held_n = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty store at the reset keep count: zero score, 1.0, clipped scores, extremes.
    queue_pair(0, 0, 0);
    queue_pair(65536, 1048575, 1048575);
    queue_pair(131071, 349525, 699050);
    queue_pair(65537, 699050, 349525);
    queue_pair(1000, 1, 2);
    queue_pair(1000, 3, 4);
    queue_pair(500, 5, 6);
    queue_pair(1, 7, 8);

    // Keep count zero acts as one and lies below the held count: store is full.
    write_keep(tkps_pkg::KeepW'(0));
    queue_pair(0, 9, 10);
    queue_pair(300, 11, 12);
    queue_pair(1, 13, 14);
    queue_pair(2, 15, 16);
    queue_pair(299, 17, 18);

    // Keep count above the depth saturates at the depth, so the store grows again.
    write_keep(tkps_pkg::KeepW'(127));
    queue_pair(65536, 19, 20);
    queue_pair(0, 21, 22);

    // Random phases across several keep counts; one phase runs without any idling.
    for (int unsigned ph = 0; ph < 9; ph++) begin
      write_keep(tkps_pkg::KeepW'(keep_plan[4'(ph)]));
      calm = (ph == 4);
      queue_random(PhaseWords);
    end

    settle();
    calm = 1'b0;
    repeat (5) @(negedge clk_i);
    $display("Checked %0d result words over %0d keep settings:", results_checked,
             settings_used);
    $display("%0d admitted, %0d scores clipped, final held count %0d, %0d mismatches.",
             admits_seen, clipped_offered, held_n, error_count);
    if (error_count == 0 && due_results.size() == 0) begin
      $display("top_k_pair_selector_tb OK");
    end else begin
      $display("top_k_pair_selector_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/tkps_pkg.sv
hw/rtl/tkps_cell.sv
hw/rtl/top_k_pair_selector.sv
hw/rtl/tkps_checker.sv
tb/top_k_pair_selector_tb.sv
